FILE: src/ssps_pkg.sv
// ----------------------------------------------------------------------------
// Shared supply power sequencer package
// Operation and consumer codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package ssps_pkg;

   localparam int DELAY_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CHAN_W = 4;
   localparam int PUMP_N = 2;
   localparam int DOOR_N = 8;
   localparam int WINDOW_N = 16;
   localparam int WATER_N = 16;

   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

   // Operation codes; the fourth code means nothing and leaves all state alone
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_REQUEST = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_PUMP   = 2'd0,
      KIND_DOOR   = 2'd1,
      KIND_WINDOW = 2'd2,
      KIND_WATER  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BINDING      = 3'd0,
      REG_ON_DELAY     = 3'd1,
      REG_OFF_DELAY    = 3'd2,
      REG_DOOR_MASK    = 3'd3,
      REG_WINDOW_MASK  = 3'd4,
      REG_WATER_MASK   = 3'd5,
      REG_ACTIVE_LEVEL = 3'd6
   } reg_idx_type;

endpackage

FILE: src/shared_supply_power_sequencer.sv
// ----------------------------------------------------------------------------
// Shared supply power sequencer
// Switches one power output shared by pumps, doors, windows and watering
// channels, with an on-delay countdown and an off-delay after the last user.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | operation, consumer_kind, channel
//   rsp     | out       | rsp_valid/ready    | remaining_delay, power_on, pin_level
//   csr     | in        | csr_we (no stall)  | csr_index, csr_wdata
//
// One beat is taken every cycle while req_ready is high. A beat is held in
// an input register, then processed in one pass into the result register,
// which offers it. A stalled result register holds the input register, and
// req_ready drops only when both are full. Synchronous reset clears the
// control state, configuration and valid flags; active_level resets to 1.
// ----------------------------------------------------------------------------
module shared_supply_power_sequencer
   import ssps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [1:0]            req_consumer_kind,
   input  logic [CHAN_W-1:0]     req_channel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DELAY_W-1:0]    rsp_remaining_delay,
   output logic                  rsp_power_on,
   output logic                  rsp_pin_level,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic                binding_ff;
   logic [DELAY_W-1:0]  on_delay_ms_ff;
   logic [DELAY_W-1:0]  off_delay_ms_ff;
   logic [DOOR_N-1:0]   door_mask_ff;
   logic [WINDOW_N-1:0] window_mask_ff;
   logic [WATER_N-1:0]  water_mask_ff;
   logic                active_level_ff;

   // Sequencer state
   logic                power_ff, power_in;
   logic                on_run_ff, on_run_in;
   logic [DELAY_W-1:0]  on_left_ff, on_left_in;
   logic                off_run_ff, off_run_in;
   logic [DELAY_W-1:0]  off_elapsed_ff, off_elapsed_in;
   logic [PUMP_N-1:0]   pumps_ff, pumps_in;
   logic [DOOR_N-1:0]   doors_ff, doors_in;
   logic [WINDOW_N-1:0] windows_ff, windows_in;
   logic [WATER_N-1:0]  water_ff, water_in;

   // Input register
   logic                s1_valid_ff;
   logic [1:0]          s1_op_ff;
   logic [1:0]          s1_kind_ff;
   logic [CHAN_W-1:0]   s1_chan_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [DELAY_W-1:0]  rsp_delay_ff, rsp_delay_in;
   logic                rsp_power_ff;
   logic                rsp_pin_ff;

   logic                advance;
   logic                req_take;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         binding_ff      <= 1'b0;
         on_delay_ms_ff  <= '0;
         off_delay_ms_ff <= '0;
         door_mask_ff    <= '0;
         window_mask_ff  <= '0;
         water_mask_ff   <= '0;
         active_level_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BINDING:      binding_ff      <= csr_wdata[0];
            REG_ON_DELAY:     on_delay_ms_ff  <= csr_wdata[DELAY_W-1:0];
            REG_OFF_DELAY:    off_delay_ms_ff <= csr_wdata[DELAY_W-1:0];
            REG_DOOR_MASK:    door_mask_ff    <= csr_wdata[DOOR_N-1:0];
            REG_WINDOW_MASK:  window_mask_ff  <= csr_wdata[WINDOW_N-1:0];
            REG_WATER_MASK:   water_mask_ff   <= csr_wdata[WATER_N-1:0];
            REG_ACTIVE_LEVEL: active_level_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // One pass over the held beat: tick, request or release; the fourth code changes no state.
   always_comb begin
      logic [DELAY_W-1:0]  hit;
      logic                none_left;
      logic                counted;

      power_in       = power_ff;
      on_run_in      = on_run_ff;
      on_left_in     = on_left_ff;
      off_run_in     = off_run_ff;
      off_elapsed_in = off_elapsed_ff;
      pumps_in       = pumps_ff;
      doors_in       = doors_ff;
      windows_in     = windows_ff;
      water_in       = water_ff;
      rsp_delay_in   = '0;
      hit            = '0;

      unique case (s1_kind_ff)
         KIND_PUMP: begin
            hit = (s1_chan_ff == '0) ? DELAY_W'(1) : DELAY_W'(2);
         end
         KIND_DOOR: begin
            if (!s1_chan_ff[CHAN_W-1]) begin
               hit = DELAY_W'((DOOR_N'(1) << s1_chan_ff[2:0]) & door_mask_ff);
            end
         end
         KIND_WINDOW: begin
            hit = DELAY_W'((WINDOW_N'(1) << s1_chan_ff) & window_mask_ff);
         end
         KIND_WATER: begin
            hit = DELAY_W'((WATER_N'(1) << s1_chan_ff) & water_mask_ff);
         end
      endcase
      counted = binding_ff && (hit != '0);

      unique case (s1_op_ff)
         OP_TICK: begin
            none_left = (pumps_ff == '0) && (doors_ff == '0) &&
                        (windows_ff == '0) && (water_ff == '0);
            if (off_run_ff && binding_ff) begin
               if (off_elapsed_ff != DELAY_MAX) begin
                  off_elapsed_in = off_elapsed_ff + DELAY_W'(1);
               end
               if (off_elapsed_in >= off_delay_ms_ff) begin
                  if (none_left) begin
                     on_run_in  = 1'b0;
                     off_run_in = 1'b0;
                     power_in   = 1'b0;
                  end else begin
                     off_elapsed_in = '0;
                  end
               end
            end
            if (on_run_in) begin
               if (on_left_ff != '0) begin
                  on_left_in = on_left_ff - DELAY_W'(1);
               end
               if (on_left_in == '0) begin
                  on_run_in = 1'b0;
               end
            end
         end
         OP_REQUEST: begin
            none_left = 1'b0;
            if (counted) begin
               power_in   = 1'b1;
               off_run_in = 1'b0;
               if (!on_run_ff) begin
                  on_run_in  = 1'b1;
                  on_left_in = on_delay_ms_ff;
               end
               unique case (s1_kind_ff)
                  KIND_PUMP:   pumps_in   = pumps_ff | hit[PUMP_N-1:0];
                  KIND_DOOR:   doors_in   = doors_ff | hit[DOOR_N-1:0];
                  KIND_WINDOW: windows_in = windows_ff | hit[WINDOW_N-1:0];
                  KIND_WATER:  water_in   = water_ff | hit[WATER_N-1:0];
               endcase
               rsp_delay_in = on_left_in;
            end
         end
         OP_RELEASE: begin
            none_left = 1'b0;
            if (counted) begin
               unique case (s1_kind_ff)
                  KIND_PUMP:   pumps_in   = pumps_ff & ~hit[PUMP_N-1:0];
                  KIND_DOOR:   doors_in   = doors_ff & ~hit[DOOR_N-1:0];
                  KIND_WINDOW: windows_in = windows_ff & ~hit[WINDOW_N-1:0];
                  KIND_WATER:  water_in   = water_ff & ~hit[WATER_N-1:0];
               endcase
               none_left = (pumps_in == '0) && (doors_in == '0) &&
                           (windows_in == '0) && (water_in == '0);
               if (none_left && !off_run_ff && power_ff) begin
                  on_run_in      = 1'b0;
                  off_run_in     = 1'b1;
                  off_elapsed_in = '0;
               end
            end
         end
         default: begin
            none_left = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff       <= 1'b0;
         on_run_ff      <= 1'b0;
         on_left_ff     <= '0;
         off_run_ff     <= 1'b0;
         off_elapsed_ff <= '0;
         pumps_ff       <= '0;
         doors_ff       <= '0;
         windows_ff     <= '0;
         water_ff       <= '0;
      end else if (advance) begin
         power_ff       <= power_in;
         on_run_ff      <= on_run_in;
         on_left_ff     <= on_left_in;
         off_run_ff     <= off_run_in;
         off_elapsed_ff <= off_elapsed_in;
         pumps_ff       <= pumps_in;
         doors_ff       <= doors_in;
         windows_ff     <= windows_in;
         water_ff       <= water_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_operation;
         s1_kind_ff <= req_consumer_kind;
         s1_chan_ff <= req_channel;
      end
      if (advance) begin
         rsp_delay_ff <= rsp_delay_in;
         rsp_power_ff <= power_in;
         rsp_pin_ff   <= power_in ? active_level_ff : !active_level_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_remaining_delay = rsp_delay_ff;
   assign rsp_power_on        = rsp_power_ff;
   assign rsp_pin_level       = rsp_pin_ff;

endmodule
